>>> hw/rtl/tilt_compensated_compass_heading_unit_defines.svh
// Assertion macros for the compass heading unit.
// Used by the top level; no other dependencies.
`ifndef TILT_COMPENSATED_COMPASS_HEADING_UNIT_DEFINES_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_UNIT_DEFINES_SVH
`ifndef SYNTH
`define TCCH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TCCH_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCCH_ASSERT(lbl, clk, rstn, prop, msg)
`define TCCH_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/tcch_pkg.sv
// Package for the compass heading unit: widths, register indexes, atan table.
// No dependencies.
package tcch_pkg;
  localparam int CordicSteps = 16;
  localparam int AccW = 40;
  localparam logic [AccW-1:0] Z90 = AccW'(589824000);
  localparam logic [2:0] RegModeTilt = 3'd0;
  localparam logic [2:0] RegMinX = 3'd1;
  localparam logic [2:0] RegMinY = 3'd2;
  localparam logic [2:0] RegMinZ = 3'd3;
  localparam logic [2:0] RegMaxX = 3'd4;
  localparam logic [2:0] RegMaxY = 3'd5;
  localparam logic [2:0] RegMaxZ = 3'd6;

  typedef struct packed {
    logic [14:0] heading_centideg;
    logic        degenerate;
  } res_t;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } smp_t;

  function automatic logic signed [AccW-1:0] atan_at(input int i);
    logic signed [AccW-1:0] r;
    case (i)
      0: r = 294912000; 1: r = 174096719; 2: r = 91987925; 3: r = 46694507;
      4: r = 23437865; 5: r = 11730358; 6: r = 5866610; 7: r = 2933484;
      8: r = 1466764; 9: r = 733385; 10: r = 366693; 11: r = 183346;
      12: r = 91673; 13: r = 45837; 14: r = 22918; 15: r = 11459;
      16: r = 5730; 17: r = 2865; 18: r = 1432; 19: r = 716; 20: r = 358;
      21: r = 179; 22: r = 90; 23: r = 45; 24: r = 22; 25: r = 11; 26: r = 6;
      27: r = 3; 28: r = 1; 29: r = 1;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

>>> hw/rtl/tcch_if.sv
// Valid/ready stream interfaces: tcch_in_if carries an smp_t sample, tcch_out_if a res_t result.
// Depends on tcch_pkg for payload types.
interface tcch_in_if;
  import tcch_pkg::*;
  logic valid;
  logic ready;
  smp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcch_out_if;
  import tcch_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/tcch_sqrt.sv
// Pipelined integer square root over 62-bit inputs, two result bits per stage (one in the last).
// Depends on tcch_pkg.
module tcch_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [61:0] v_i,
  output logic [30:0] r_o
);
  import tcch_pkg::*;
  localparam int Stg = 16;
  logic [61:0] rem_in [Stg];
  logic [30:0] root_in [Stg];
  logic [61:0] rem_q [Stg];
  logic [30:0] root_q [Stg];
  logic [61:0] rem_d [Stg];
  logic [30:0] root_d [Stg];

  // Stage inputs: the first stage takes the operand, later ones the previous stage.
  always_comb begin
    rem_in[0] = v_i;
    root_in[0] = '0;
    for (int s = 1; s < Stg; s++) begin
      rem_in[s] = rem_q[s-1];
      root_in[s] = root_q[s-1];
    end
  end

  // Each stage decides two result bits (the last stage one), highest first, by compare and subtract.
  always_comb begin
    logic [61:0] rm;
    logic [30:0] rt;
    logic [63:0] tr;
    int b;
    for (int s = 0; s < Stg; s++) begin
      rm = rem_in[s];
      rt = root_in[s];
      for (int j = 0; j < 2; j++) begin
        b = 30 - 2 * s - j;
        if (b >= 0) begin
          tr = ({33'd0, rt} << (b + 1)) | (64'd1 << (2 * b));
          if ({2'b0, rm} >= tr) begin
            rm = rm - tr[61:0];
            rt = rt | (31'd1 << b);
          end
        end
      end
      rem_d[s] = rm;
      root_d[s] = rt;
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stg; s++) begin
        rem_q[s] <= '0;
        root_q[s] <= '0;
      end
    end else if (en_i) begin
      for (int s = 0; s < Stg; s++) begin
        rem_q[s] <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign r_o = root_q[Stg-1];
endmodule

>>> hw/rtl/tilt_compensated_compass_heading_unit.sv
// Tilt-compensated compass heading unit: accepts one sample per cycle unless the output stalls.
// The pipe has six front stages (offset, two stages per cross product with
// the magnitudes in the second stage of N, normalize), 16 square-root
// stages, 16 CORDIC stages and one rounding stage. Throughput is one item
// per cycle; a stall at the output freezes the pipe. Reset loads the
// default calibration and tilt mode and empties the pipe.
`include "tilt_compensated_compass_heading_unit_defines.svh"
module tilt_compensated_compass_heading_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tcch_in_if.sink     in_if,
  tcch_out_if.source  out_if
);
  import tcch_pkg::*;
  localparam int Pre = 6;
  localparam int SqS = 16;
  localparam int Lat = Pre + SqS + CordicSteps + 1;

  // Configuration registers.
  logic mode_q;
  logic signed [15:0] mn_q [3];
  logic signed [15:0] mx_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      mn_q[0] <= -16'sd190; mn_q[1] <= -16'sd850; mn_q[2] <= 16'sd3460;
      mx_q[0] <= 16'sd2100; mx_q[1] <= 16'sd1280; mx_q[2] <= 16'sd3800;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegModeTilt: mode_q <= cfg_data_i[0];
        RegMinX: mn_q[0] <= cfg_data_i;
        RegMinY: mn_q[1] <= cfg_data_i;
        RegMinZ: mn_q[2] <= cfg_data_i;
        RegMaxX: mx_q[0] <= cfg_data_i;
        RegMaxY: mx_q[1] <= cfg_data_i;
        RegMaxZ: mx_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global stall: whole pipe advances when the output is free or taken.
  logic adv;
  logic [Lat-1:0] v_q;
  assign adv = !v_q[Lat-1] || out_if.ready;
  assign in_if.ready = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Lat-2:0], in_if.valid};
  end

  // Stage 1: hard-iron offset, wraps to 16 bits.
  logic signed [15:0] m1_q [3];
  logic signed [15:0] a1_q [3];
  logic mode1_q;
  logic signed [15:0] raw [3];
  assign raw[0] = in_if.data.mag_x;
  assign raw[1] = in_if.data.mag_y;
  assign raw[2] = in_if.data.mag_z;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [16:0] s;
        logic signed [16:0] off;
        s = 17'(mn_q[k]) + 17'(mx_q[k]);
        off = (s + 17'(s[16])) >>> 1;
        m1_q[k] <= 16'(17'(raw[k]) - off);
      end
      a1_q[0] <= in_if.data.accel_x;
      a1_q[1] <= in_if.data.accel_y;
      a1_q[2] <= in_if.data.accel_z;
      mode1_q <= mode_q;
    end
  end

  // Stage 2: partial products of E = m x a.
  logic signed [31:0] p2_q [6];
  logic signed [15:0] a2_q [3];
  logic signed [15:0] m2_q [3];
  logic mode2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q[0] <= m1_q[1] * a1_q[2]; p2_q[1] <= m1_q[2] * a1_q[1];
      p2_q[2] <= m1_q[2] * a1_q[0]; p2_q[3] <= m1_q[0] * a1_q[2];
      p2_q[4] <= m1_q[0] * a1_q[1]; p2_q[5] <= m1_q[1] * a1_q[0];
      a2_q <= a1_q; m2_q <= m1_q; mode2_q <= mode1_q;
    end
  end

  // Stage 3: E components.
  logic signed [32:0] e3_q [3];
  logic signed [15:0] a3_q [3];
  logic signed [15:0] m3_q [3];
  logic mode3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_q[0] <= 33'(p2_q[0]) - 33'(p2_q[1]);
      e3_q[1] <= 33'(p2_q[2]) - 33'(p2_q[3]);
      e3_q[2] <= 33'(p2_q[4]) - 33'(p2_q[5]);
      a3_q <= a2_q; m3_q <= m2_q; mode3_q <= mode2_q;
    end
  end

  // Stage 4: partial products of N = a x E.
  logic signed [48:0] q4_q [6];
  logic signed [15:0] m4_q [3];
  logic mode4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      q4_q[0] <= a3_q[1] * e3_q[2]; q4_q[1] <= a3_q[2] * e3_q[1];
      q4_q[2] <= a3_q[2] * e3_q[0]; q4_q[3] <= a3_q[0] * e3_q[2];
      q4_q[4] <= a3_q[0] * e3_q[1]; q4_q[5] <= a3_q[1] * e3_q[0];
      m4_q <= m3_q; mode4_q <= mode3_q;
    end
  end

  // Stage 5: N components and magnitudes, simple mode substituted.
  logic [49:0] n5_q [3];
  logic nxpos5_q;
  logic zero5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [49:0] n [3];
      if (mode4_q) begin
        n[0] = 50'(q4_q[0]) - 50'(q4_q[1]);
        n[1] = 50'(q4_q[2]) - 50'(q4_q[3]);
        n[2] = 50'(q4_q[4]) - 50'(q4_q[5]);
      end else begin
        n[0] = 50'(m4_q[0]); n[1] = 50'(m4_q[1]); n[2] = '0;
      end
      for (int k = 0; k < 3; k++) n5_q[k] <= n[k][49] ? 50'(-n[k]) : 50'(n[k]);
      nxpos5_q <= !n[0][49] && (n[0] != 0);
      zero5_q <= (n[0] == 0) && (n[1] == 0) && (n[2] == 0);
    end
  end

  // Stage 6: normalize so the largest magnitude lies in [2^29, 2^30).
  logic [29:0] ax6_q, ay6_q, az6_q;
  logic nxpos6_q, zero6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [49:0] m;
      int lz;
      m = n5_q[0] | n5_q[1] | n5_q[2];
      lz = 0;
      for (int b = 0; b < 50; b++) if (m[b]) lz = b;
      if (lz >= 29) begin
        ax6_q <= 30'(n5_q[0] >> (lz - 29));
        ay6_q <= 30'(n5_q[1] >> (lz - 29));
        az6_q <= 30'(n5_q[2] >> (lz - 29));
      end else begin
        ax6_q <= 30'(n5_q[0] << (29 - lz));
        ay6_q <= 30'(n5_q[1] << (29 - lz));
        az6_q <= 30'(n5_q[2] << (29 - lz));
      end
      nxpos6_q <= nxpos5_q; zero6_q <= zero5_q;
    end
  end

  // Square root of the transverse energy; x travels alongside.
  logic [59:0] sqy, sqz;
  logic [61:0] sq_in;
  logic [30:0] sq_r;
  assign sqy = ay6_q * ay6_q;
  assign sqz = az6_q * az6_q;
  assign sq_in = 62'(sqy) + 62'(sqz);
  tcch_sqrt u_sqrt (.clk_i, .rst_ni, .en_i(adv), .v_i(sq_in), .r_o(sq_r));
  logic [29:0] axd_q [SqS];
  logic [SqS-1:0] pos_q, zro_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      axd_q[0] <= ax6_q; pos_q[0] <= nxpos6_q; zro_q[0] <= zero6_q;
      for (int k = 1; k < SqS; k++) axd_q[k] <= axd_q[k-1];
      pos_q[SqS-1:1] <= pos_q[SqS-2:0];
      zro_q[SqS-1:1] <= zro_q[SqS-2:0];
    end
  end

  // CORDIC vectoring, one step per stage.
  logic signed [AccW-1:0] cx_in [CordicSteps];
  logic signed [AccW-1:0] cy_in [CordicSteps];
  logic signed [AccW-1:0] cz_in [CordicSteps];
  logic czr_in [CordicSteps];
  logic signed [AccW-1:0] cx_q [CordicSteps];
  logic signed [AccW-1:0] cy_q [CordicSteps];
  logic signed [AccW-1:0] cz_q [CordicSteps];
  logic czr_q [CordicSteps];

  // Step inputs: the first step takes the start vector, turned by -90 degrees
  // when it points backward; later steps take the previous step.
  always_comb begin
    logic signed [AccW-1:0] x0;
    x0 = pos_q[SqS-1] ? -AccW'(axd_q[SqS-1]) : AccW'(axd_q[SqS-1]);
    if (x0 < 0) begin
      cx_in[0] = AccW'(sq_r); cy_in[0] = -x0; cz_in[0] = Z90;
    end else begin
      cx_in[0] = x0; cy_in[0] = AccW'(sq_r); cz_in[0] = '0;
    end
    czr_in[0] = zro_q[SqS-1];
    for (int i = 1; i < CordicSteps; i++) begin
      cx_in[i] = cx_q[i-1];
      cy_in[i] = cy_q[i-1];
      cz_in[i] = cz_q[i-1];
      czr_in[i] = czr_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < CordicSteps; i++) begin
        if (cy_in[i] > 0) begin
          cx_q[i] <= cx_in[i] + (cy_in[i] >>> i);
          cy_q[i] <= cy_in[i] - (cx_in[i] >>> i);
          cz_q[i] <= cz_in[i] + atan_at(i);
        end else begin
          cx_q[i] <= cx_in[i] - (cy_in[i] >>> i);
          cy_q[i] <= cy_in[i] + (cx_in[i] >>> i);
          cz_q[i] <= cz_in[i] - atan_at(i);
        end
        czr_q[i] <= czr_in[i];
      end
    end
  end

  // Final rounding and clamp into the output register.
  res_t res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [AccW-1:0] z;
      z = (cz_q[CordicSteps-1] + AccW'(32768)) >>> 16;
      if (czr_q[CordicSteps-1] || cz_q[CordicSteps-1] < 0) res_q.heading_centideg <= '0;
      else if (z > 18000) res_q.heading_centideg <= 15'd18000;
      else res_q.heading_centideg <= 15'(z);
      res_q.degenerate <= czr_q[CordicSteps-1];
    end
  end
  assign out_if.valid = v_q[Lat-1];
  assign out_if.data = res_q;

  `TCCH_ASSERT(a_hold, clk_i, rst_ni, out_if.valid && !out_if.ready |=> out_if.valid, "lost")
  `TCCH_ASSERT(a_rng, clk_i, rst_ni, out_if.valid |-> res_q.heading_centideg <= 15'd18000, "rng")
  `TCCH_ASSERT(a_deg, clk_i, rst_ni, out_if.valid && res_q.degenerate |-> res_q.heading_centideg == 0, "deg")
endmodule

>>> bench/tb.sv
// Self-checking bench for the tilt-compensated compass heading unit.
// Needs tcch_pkg, the tcch_in_if/tcch_out_if interfaces and the top level RTL.
module tb;
  import tcch_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 80;
  localparam longint Quarter = 589824000;

  // Item shapes for the random part.
  typedef enum int {
    ShapeFull, ShapeSmall, ShapeNearOffset, ShapeNoGravity, ShapeMixed
  } shape_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  tcch_in_if in_if ();
  tcch_out_if out_if ();

  tilt_compensated_compass_heading_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  // Local copy of the calibration and mode registers.
  bit tilt_on;
  logic signed [15:0] cal_min [3];
  logic signed [15:0] cal_max [3];

  smp_t samples_pending [$];
  res_t headings_due [$];
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit in_fired;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned items_in;
  int unsigned results_out;
  int unsigned degenerate_seen;

  longint arctan_steps [32] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358, 5866610,
    2933484, 1466764, 733385, 366693, 183346, 91673, 45837, 22918, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1, 0, 0
  };

  // Clock with a period of two time units.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard-iron correction: subtract the truncated midpoint and wrap to 16 bits.
  function automatic longint hard_iron_fix(logic signed [15:0] raw,
                                           logic signed [15:0] lo,
                                           logic signed [15:0] hi);
    int off;
    logic [15:0] w;
    off = (int'(lo) + int'(hi)) / 2;
    w = 16'(int'(raw) - off);
    return longint'($signed(w));
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Angle of (-nx, |(ny,nz)|) in centidegrees by vectoring CORDIC.
  function automatic int unsigned north_angle(longint nx, longint ny, longint nz);
    longint unsigned ux, uy, uz, top;
    longint x, y, z, t, dx, dy;
    ux = (nx < 0) ? longint'(-nx) : longint'(nx);
    uy = (ny < 0) ? longint'(-ny) : longint'(ny);
    uz = (nz < 0) ? longint'(-nz) : longint'(nz);
    top = ux;
    if (uy > top) top = uy;
    if (uz > top) top = uz;
    while (top >= (64'd1 << 30)) begin
      ux = ux >> 1; uy = uy >> 1; uz = uz >> 1; top = top >> 1;
    end
    while (top < (64'd1 << 29)) begin
      ux = ux << 1; uy = uy << 1; uz = uz << 1; top = top << 1;
    end
    x = (nx > 0) ? -longint'(ux) : longint'(ux);
    y = longint'(root_floor(uy * uy + uz * uz));
    z = 0;
    // Rotate into the right half-plane when the vector points backward.
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = Quarter;
    end
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + arctan_steps[i];
      end else begin
        x = x - dx; y = y + dy; z = z - arctan_steps[i];
      end
    end
    if (z < 0) return 0;
    z = (z + 32768) >>> 16;
    return (z > 18000) ? 18000 : int'(z);
  endfunction

  function automatic res_t predict_heading(smp_t s);
    longint mx, my, mz, ax, ay, az, ex, ey, ez, nx, ny, nz;
    res_t r;
    mx = hard_iron_fix(s.mag_x, cal_min[0], cal_max[0]);
    my = hard_iron_fix(s.mag_y, cal_min[1], cal_max[1]);
    mz = hard_iron_fix(s.mag_z, cal_min[2], cal_max[2]);
    if (tilt_on) begin
      ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
      ex = my * az - mz * ay;
      ey = mz * ax - mx * az;
      ez = mx * ay - my * ax;
      nx = ay * ez - az * ey;
      ny = az * ex - ax * ez;
      nz = ax * ey - ay * ex;
    end else begin
      nx = mx; ny = my; nz = 0;
    end
    if (nx == 0 && ny == 0 && nz == 0) begin
      r.heading_centideg = '0;
      r.degenerate = 1'b1;
    end else begin
      r.heading_centideg = 15'(north_angle(nx, ny, nz));
      r.degenerate = 1'b0;
    end
    return r;
  endfunction

  // Driver: a new sample is offered only once the previous transfer is done.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_fired) begin
        if (samples_pending.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid = 1'b1;
          in_if.data = samples_pending[0];
        end else begin
          in_if.valid = 1'b0;
        end
      end
      in_fired = 1'b0;
      out_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        headings_due.push_back(predict_heading(in_if.data));
        void'(samples_pending.pop_front());
        in_fired = 1'b1;
        items_in++;
      end
      if (out_if.valid && out_if.ready) begin
        results_out++;
        if (out_if.data.degenerate) degenerate_seen++;
        if (headings_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result heading=%0d degenerate=%0b",
                     out_if.data.heading_centideg, out_if.data.degenerate);
        end else begin
          if (out_if.data.heading_centideg !== headings_due[0].heading_centideg ||
              out_if.data.degenerate !== headings_due[0].degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d expected heading=%0d degenerate=%0b, got %0d %0b",
                       results_out, headings_due[0].heading_centideg,
                       headings_due[0].degenerate, out_if.data.heading_centideg,
                       out_if.data.degenerate);
          end
          void'(headings_due.pop_front());
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // One register write, mirrored into the local copy.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      RegModeTilt: tilt_on = val[0];
      RegMinX: cal_min[0] = val;
      RegMinY: cal_min[1] = val;
      RegMinZ: cal_min[2] = val;
      RegMaxX: cal_max[0] = val;
      RegMaxY: cal_max[1] = val;
      RegMaxZ: cal_max[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_calibration(bit tilt, logic [15:0] lx, logic [15:0] ly,
                                 logic [15:0] lz, logic [15:0] hx,
                                 logic [15:0] hy, logic [15:0] hz);
    write_reg(RegModeTilt, {15'd0, tilt});
    write_reg(RegMinX, lx);
    write_reg(RegMinY, ly);
    write_reg(RegMinZ, lz);
    write_reg(RegMaxX, hx);
    write_reg(RegMaxY, hy);
    write_reg(RegMaxZ, hz);
  endtask

  task automatic add_sample(logic [15:0] mx, logic [15:0] my, logic [15:0] mz,
                            logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    smp_t s;
    s.mag_x = mx; s.mag_y = my; s.mag_z = mz;
    s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
    samples_pending.push_back(s);
  endtask

  function automatic logic [15:0] pick_value(shape_e shape, int axis, bit is_mag);
    int off;
    case (shape)
      ShapeFull: return 16'($urandom);
      ShapeSmall: return 16'($urandom_range(0, 40) - 20);
      ShapeNearOffset: begin
        if (!is_mag) return 16'($urandom);
        off = (int'(cal_min[axis]) + int'(cal_max[axis])) / 2;
        return 16'(off + $urandom_range(0, 6) - 3);
      end
      ShapeNoGravity: return is_mag ? 16'($urandom) : 16'($urandom_range(0, 2) - 1);
      default: return ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
    endcase
  endfunction

  // Queue random samples and wait until every result has come back.
  task automatic run_batch(int n, int unsigned src_pct, int unsigned sink_pct);
    shape_e shape;
    int pick;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) shape = ShapeFull;
      else if (pick < 60) shape = ShapeSmall;
      else if (pick < 70) shape = ShapeNearOffset;
      else if (pick < 75) shape = ShapeNoGravity;
      else shape = ShapeMixed;
      add_sample(pick_value(shape, 0, 1), pick_value(shape, 1, 1),
                 pick_value(shape, 2, 1), pick_value(shape, 0, 0),
                 pick_value(shape, 1, 0), pick_value(shape, 2, 0));
    end
    drain();
  endtask

  task automatic drain();
    while (samples_pending.size() > 0 || headings_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Stimulus sequence: reset, directed corners, then random phases.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegModeTilt;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    in_fired = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    tilt_on = 1'b1;
    cal_min = '{-16'sd190, -16'sd850, 16'sd3460};
    cal_max = '{16'sd2100, 16'sd1280, 16'sd3800};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners with the reset calibration in tilt mode.
    add_sample(16'd955, 16'd215, 16'd3630, 16'd100, 16'd200, 16'd300);
    add_sample(16'd1000, 16'd500, 16'd100, 16'd0, 16'd0, 16'd0);
    add_sample(16'd1955, 16'd1215, 16'd4630, 16'd1000, 16'd1000, 16'd1000);
    add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_sample(16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF);
    add_sample(16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF);
    add_sample(16'd2955, 16'd215, 16'd3630, 16'd0, 16'd0, 16'd1000);
    add_sample(-16'sd1045, 16'd215, 16'd3630, 16'd0, 16'd0, 16'd1000);
    add_sample(16'd955, 16'd2215, 16'd3630, 16'd0, 16'd0, 16'd1000);
    add_sample(16'd955, 16'd215, 16'd3630, 16'd0, 16'd0, 16'd0);
    run_batch(0, 0, 0);

    // Unknown index must leave the registers alone; simple mode corners follow.
    write_reg(RegUnused, 16'hFFFF);
    write_reg(RegModeTilt, 16'd0);
    add_sample(16'd955, 16'd215, 16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(16'd955, 16'd1215, 16'd7, 16'd1, 16'd2, 16'd3);
    add_sample(16'd1955, 16'd215, 16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(-16'sd45, 16'd215, 16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(-16'sd45, 16'd216, 16'd0, 16'd0, 16'd0, 16'd0);
    add_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    run_batch(0, 0, 0);

    // Random phases over several calibrations, both modes and all idle mixes.
    set_calibration(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    run_batch(90, 0, 0);
    set_calibration(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    run_batch(90, 53, 0);
    set_calibration(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    run_batch(90, 0, 53);
    set_calibration(1'b0, -16'sd3, 16'd0, -16'sd7, 16'd0, 16'd4, 16'd2);
    run_batch(90, 18, 18);
    set_calibration(1'b1, -16'sd190, -16'sd850, 16'd3460, 16'd2100, 16'd1280, 16'd3800);
    run_batch(110, 53, 0);
    set_calibration(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
    run_batch(80, 0, 53);
    set_calibration(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
    run_batch(80, 18, 18);
    set_calibration(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
    run_batch(80, 0, 0);

    $display("Run covered %0d samples and %0d headings (%0d degenerate) in %0d cycles,",
             items_in, results_out, degenerate_seen, cycles);
    $display("over eight calibrations, both modes and four idle mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && headings_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tcch_pkg.sv
hw/rtl/tcch_if.sv
hw/rtl/tcch_sqrt.sv
hw/rtl/tilt_compensated_compass_heading_unit.sv
bench/tb.sv
